// ===== rtl/core/dtsc_pkg.sv =====
// Package for the distinct tuple set counter.
// Holds default sizes, field widths, the sequencer state type and the compare status type.
// No dependencies.
package dtsc_pkg;

	localparam int MAX_PATTERNS_DEF   = 256;
	localparam int KEYS_PER_TUPLE_DEF = 4;
	localparam int INDEX_BITS_DEF     = 32;

	localparam int FIELD_KEYS  = 4;
	localparam int FIELD_BITS  = 32;
	localparam int SLOT_BITS   = 8;
	localparam int COUNT_BITS  = 9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} seq_state_t;

	// Verdict of the compare unit on the registered read data from the pattern table.
	typedef struct packed {
		logic hit;
		logic miss_done;
	} cmp_status_t;

endpackage

// ===== rtl/core/dtsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the pattern table. No package dependencies.
module dtsc_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/dtsc_cmp.sv =====
// Shared tuple compare unit: checks one stored entry against the search key
// per cycle, all keys at once, and reports a hit or the end of a scan that missed.
// Depends on dtsc_pkg.
module dtsc_cmp #(
	parameter int KEYS = 4,
	parameter int IBITS = 32
) (
	input  logic [KEYS*IBITS-1:0] entry,
	input  logic [KEYS*IBITS-1:0] key,
	input  logic                  entry_valid,
	input  logic                  scanning,
	input  logic                  all_issued,
	output dtsc_pkg::cmp_status_t status
);
	import dtsc_pkg::*;

	logic [KEYS-1:0] key_eq;
	logic            eq;

	always_comb begin
		for (int k = 0; k < KEYS; k++) begin
			key_eq[k] = (entry[k*IBITS +: IBITS] == key[k*IBITS +: IBITS]);
		end
		eq = &key_eq;
		status.hit       = scanning && entry_valid && eq;
		// The scan has missed once every stored entry has been read and the
		// last read came back without a match.
		status.miss_done = scanning && !entry_valid && all_issued;
	end

endmodule

// ===== rtl/core/distinct_tuple_set_counter.sv =====
// Distinct tuple set counter, top level.
// Holds the sequencer, the pattern table RAM and the shared compare unit.
// Depends on dtsc_pkg, dtsc_ram and dtsc_cmp.
//
// Usage: each input beat is one terrain segment with a start-of-sector flag and
// four texture indices; the first KEYS_PER_TUPLE indices, each in its low
// INDEX_BITS bits, form a tuple. A set start_of_sector empties the table of
// stored tuples before the lookup. The block walks the table from slot 0 upward,
// reading one entry per cycle from the RAM into the compare unit. The first
// match ends the walk; on a miss the tuple is written at the tail, or dropped
// with table_full set when all MAX_PATTERNS slots are in use. Exactly one output
// beat follows each input beat.
//
// Search time: a match at slot M reads slots 0 to M, and a miss reads all N stored
// entries, or none on an empty table, so a full table gives the longest search.
// in_stall is high from acceptance until the result enters the output register,
// which holds it while out_stall is high; the next item may be searched meanwhile
// and waits at its end. Reset empties the table; RAM contents are never read
// before they are written.
module distinct_tuple_set_counter #(
	parameter int MAX_PATTERNS   = dtsc_pkg::MAX_PATTERNS_DEF,
	parameter int KEYS_PER_TUPLE = dtsc_pkg::KEYS_PER_TUPLE_DEF,
	parameter int INDEX_BITS     = dtsc_pkg::INDEX_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            start_of_sector,
	input  logic [dtsc_pkg::FIELD_BITS-1:0] tex_index_a,
	input  logic [dtsc_pkg::FIELD_BITS-1:0] tex_index_b,
	input  logic [dtsc_pkg::FIELD_BITS-1:0] tex_index_c,
	input  logic [dtsc_pkg::FIELD_BITS-1:0] tex_index_d,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            already_present,
	output logic [dtsc_pkg::SLOT_BITS-1:0]  pattern_slot,
	output logic [dtsc_pkg::COUNT_BITS-1:0] distinct_count,
	output logic                            table_full
);
	import dtsc_pkg::*;

	localparam int ADDR_W = $clog2(MAX_PATTERNS);
	localparam int CNT_W  = $clog2(MAX_PATTERNS + 1);
	localparam int KEY_W  = KEYS_PER_TUPLE * INDEX_BITS;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PATTERNS);

	// Sequencer and search state.
	seq_state_t       state_q, state_d;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] addr_q;
	logic             rd_vld_s1;
	logic [CNT_W-1:0] rd_addr_s1;

	// Result held until the output register is free.
	logic             res_found_q;
	logic             res_full_q;
	logic [CNT_W-1:0] res_slot_q;

	// Output register.
	logic                  out_valid_q;
	logic                  out_present_q;
	logic [SLOT_BITS-1:0]  out_slot_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic                  out_full_q;

	logic [FIELD_BITS-1:0] field_idx [FIELD_KEYS];
	logic [KEY_W-1:0]      key_in;
	logic [KEY_W-1:0]      rd_entry;
	logic                  accept;
	logic                  issue;
	logic                  all_issued;
	logic                  scanning;
	logic                  out_free;
	logic                  ram_we;
	cmp_status_t           cmp_st;
	logic [31:0]           slot_ext;
	logic [31:0]           cnt_ext;

	assign field_idx[0] = tex_index_a;
	assign field_idx[1] = tex_index_b;
	assign field_idx[2] = tex_index_c;
	assign field_idx[3] = tex_index_d;

	// Pack the used keys, each cut to its low INDEX_BITS bits.
	always_comb begin
		for (int k = 0; k < KEYS_PER_TUPLE; k++) begin
			key_in[k*INDEX_BITS +: INDEX_BITS] = field_idx[k][INDEX_BITS-1:0];
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign scanning   = (state_q == ST_SCAN);
	assign all_issued = (addr_q >= cnt_q);
	assign out_free   = !out_valid_q || !out_stall;

	// A read is issued each cycle of the walk until a match turns up or every
	// stored entry has been requested.
	assign issue  = scanning && !all_issued && !cmp_st.hit;
	// A missed tuple goes to the tail if there is room.
	assign ram_we = cmp_st.miss_done && (cnt_q < MAX_CNT);

	dtsc_ram #(
		.WIDTH(KEY_W),
		.DEPTH(MAX_PATTERNS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(key_q),
		.re   (issue),
		.raddr(addr_q[ADDR_W-1:0]),
		.rdata(rd_entry)
	);

	dtsc_cmp #(
		.KEYS (KEYS_PER_TUPLE),
		.IBITS(INDEX_BITS)
	) u_cmp (
		.entry      (rd_entry),
		.key        (key_q),
		.entry_valid(rd_vld_s1),
		.scanning   (scanning),
		.all_issued (all_issued),
		.status     (cmp_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cmp_st.hit || cmp_st.miss_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers of the walk and the stored count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (accept) begin
				addr_q <= '0;
				if (start_of_sector) begin
					cnt_q <= '0;
				end
			end else if (issue) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			if (ram_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Payload registers of the search.
	always_ff @(posedge clk) begin
		rd_addr_s1 <= addr_q;
		if (accept) begin
			key_q <= key_in;
		end
		if (cmp_st.hit) begin
			res_found_q <= 1'b1;
			res_full_q  <= 1'b0;
			res_slot_q  <= rd_addr_s1;
		end else if (cmp_st.miss_done) begin
			res_found_q <= 1'b0;
			res_full_q  <= !ram_we;
			res_slot_q  <= ram_we ? cnt_q : '0;
		end
	end

	assign slot_ext = 32'(res_slot_q);
	assign cnt_ext  = 32'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			out_present_q <= res_found_q;
			out_slot_q    <= slot_ext[SLOT_BITS-1:0];
			out_count_q   <= cnt_ext[COUNT_BITS-1:0];
			out_full_q    <= res_full_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign already_present = out_present_q;
	assign pattern_slot    = out_slot_q;
	assign distinct_count  = out_count_q;
	assign table_full      = out_full_q;

endmodule

// ===== tb/dtsc_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the distinct tuple set counter: keeps its own copy of the tuple table,
// predicts a result for every accepted input beat and compares every accepted output beat.
// Depends on dtsc_pkg.
module dtsc_checker #(
	parameter int MAX_PATTERNS   = dtsc_pkg::MAX_PATTERNS_DEF,
	parameter int KEYS_PER_TUPLE = dtsc_pkg::KEYS_PER_TUPLE_DEF,
	parameter int INDEX_BITS     = dtsc_pkg::INDEX_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            start_of_sector,
	input  logic [dtsc_pkg::FIELD_BITS-1:0] tex_index_a,
	input  logic [dtsc_pkg::FIELD_BITS-1:0] tex_index_b,
	input  logic [dtsc_pkg::FIELD_BITS-1:0] tex_index_c,
	input  logic [dtsc_pkg::FIELD_BITS-1:0] tex_index_d,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            already_present,
	input  logic [dtsc_pkg::SLOT_BITS-1:0]  pattern_slot,
	input  logic [dtsc_pkg::COUNT_BITS-1:0] distinct_count,
	input  logic                            table_full,
	output int                              failures,
	output int                              pending
);
	import dtsc_pkg::*;

	typedef logic [FIELD_KEYS-1:0][FIELD_BITS-1:0] tuple_t;

	typedef struct packed {
		logic                  present;
		logic [SLOT_BITS-1:0]  slot;
		logic [COUNT_BITS-1:0] count;
		logic                  full;
	} lookup_result_t;

	localparam logic [FIELD_BITS-1:0] INDEX_MASK = (INDEX_BITS >= FIELD_BITS) ?
		{FIELD_BITS{1'b1}} : FIELD_BITS'((64'd1 << INDEX_BITS) - 64'd1);

	tuple_t         stored_tuples [MAX_PATTERNS];
	int unsigned    tuples_held;
	lookup_result_t lookups_due [$];

	task automatic report_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		$display("MISMATCH at %0t: %s expected %0d, got %0d", $time, what, want, got);
		failures++;
	endtask

	// Looks the tuple up in the mirrored table, appends it when new and there is room.
	function automatic lookup_result_t record_tuple(input logic clear, input tuple_t raw);
		lookup_result_t res;
		tuple_t         key;
		int             hit_slot;
		int             k;
		int             s;
		key = '0;
		for (k = 0; k < KEYS_PER_TUPLE && k < FIELD_KEYS; k++)
			key[k] = raw[k] & INDEX_MASK;
		if (clear)
			tuples_held = 0;
		hit_slot = -1;
		for (s = 0; s < int'(tuples_held) && hit_slot < 0; s++)
			if (stored_tuples[s] == key)
				hit_slot = s;
		res = '0;
		if (hit_slot >= 0) begin
			res.present = 1'b1;
			res.slot = hit_slot[SLOT_BITS-1:0];
		end else if (tuples_held < MAX_PATTERNS) begin
			stored_tuples[tuples_held] = key;
			res.slot = tuples_held[SLOT_BITS-1:0];
			tuples_held++;
		end else begin
			res.full = 1'b1;
		end
		res.count = tuples_held[COUNT_BITS-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		if (!arst_n) begin
			tuples_held = 0;
			failures = 0;
			lookups_due.delete();
			pending <= 0;
		end else begin
			// Output first: a beat leaving now always belongs to an earlier input beat.
			if (out_valid && !out_stall) begin
				if (lookups_due.size() == 0) begin
					report_mismatch("result beat with nothing outstanding", 0, 1);
				end else begin
					want = lookups_due.pop_front();
					if (already_present !== want.present)
						report_mismatch("already_present", want.present, already_present);
					if (pattern_slot !== want.slot)
						report_mismatch("pattern_slot", want.slot, pattern_slot);
					if (distinct_count !== want.count)
						report_mismatch("distinct_count", want.count, distinct_count);
					if (table_full !== want.full)
						report_mismatch("table_full", want.full, table_full);
				end
			end
			if (in_valid && !in_stall)
				lookups_due.push_back(record_tuple(start_of_sector,
					{tex_index_d, tex_index_c, tex_index_b, tex_index_a}));
			pending <= lookups_due.size();
		end
	end

endmodule

// ===== tb/tb_distinct_tuple_set_counter.sv =====
`timescale 1ns / 1ps
// Testbench top for the distinct tuple set counter: clock, reset, stimulus and verdict.
// Depends on dtsc_pkg, the block itself and dtsc_checker, which does all the checking.
module tb_distinct_tuple_set_counter;
	import dtsc_pkg::*;

	localparam int HALF_PERIOD     = 4;
	localparam int RESET_CYCLES    = 11;
	localparam int TARGET_SEGMENTS = 950;
	localparam int PHASE_LEN       = 40;
	localparam int HOLD_AT_SEGMENT = 100;
	localparam int HOLD_CYCLES     = 500;
	localparam int DRAIN_CYCLES    = MAX_PATTERNS_DEF + 16;
	// Even if every segment walked a full table, the run with all its stalls would
	// end well inside this bound.
	localparam int CYCLE_LIMIT     = 3_000_000;

	// How the two sides idle; the sender moves through these every PHASE_LEN beats.
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// Index 0 is tex_index_a, index 3 is tex_index_d.
	typedef logic [FIELD_KEYS-1:0][FIELD_BITS-1:0] tuple_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  start_of_sector = 1'b0;
	logic [FIELD_BITS-1:0] tex_index_a = '0;
	logic [FIELD_BITS-1:0] tex_index_b = '0;
	logic [FIELD_BITS-1:0] tex_index_c = '0;
	logic [FIELD_BITS-1:0] tex_index_d = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  already_present;
	logic [SLOT_BITS-1:0]  pattern_slot;
	logic [COUNT_BITS-1:0] distinct_count;
	logic                  table_full;

	int         failures;
	int         pending;
	int         cycle_count = 0;
	int         segments_sent = 0;
	idle_mode_t idle_mode = IDLE_NONE;
	bit         hold_request = 1'b0;
	bit         hold_done = 1'b0;
	bit         draining = 1'b0;
	tuple_t     sector_tuples [$];

	distinct_tuple_set_counter DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.start_of_sector (start_of_sector),
		.tex_index_a     (tex_index_a),
		.tex_index_b     (tex_index_b),
		.tex_index_c     (tex_index_c),
		.tex_index_d     (tex_index_d),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.already_present (already_present),
		.pattern_slot    (pattern_slot),
		.distinct_count  (distinct_count),
		.table_full      (table_full)
	);

	// The checker watches both channels beside the block and hands back its tally.
	dtsc_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.start_of_sector (start_of_sector),
		.tex_index_a     (tex_index_a),
		.tex_index_b     (tex_index_b),
		.tex_index_c     (tex_index_c),
		.tex_index_d     (tex_index_d),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.already_present (already_present),
		.pattern_slot    (pattern_slot),
		.distinct_count  (distinct_count),
		.table_full      (table_full),
		.failures        (failures),
		.pending         (pending)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic tuple_t tuple_of(input logic [FIELD_BITS-1:0] a,
			input logic [FIELD_BITS-1:0] b, input logic [FIELD_BITS-1:0] c,
			input logic [FIELD_BITS-1:0] d);
		return {d, c, b, a};
	endfunction

	// Mostly uniform indices, with the all-zero, all-one and one-hot values mixed in
	// so that tuples collide on some fields and differ on others.
	function automatic logic [FIELD_BITS-1:0] pick_index();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return FIELD_BITS'(1) << $urandom_range(0, FIELD_BITS - 1);
			default: return $urandom();
		endcase
	endfunction

	function automatic tuple_t fresh_tuple();
		tuple_t t;
		int     k;
		for (k = 0; k < FIELD_KEYS; k++)
			t[k] = pick_index();
		return t;
	endfunction

	// A near miss: one field changed, either by a single bit or to another value.
	function automatic tuple_t variant_of(input tuple_t base);
		int k;
		k = $urandom_range(0, FIELD_KEYS - 1);
		if ($urandom_range(0, 1) == 0)
			base[k] = base[k] ^ (FIELD_BITS'(1) << $urandom_range(0, FIELD_BITS - 1));
		else
			base[k] = pick_index();
		return base;
	endfunction

	// Offers one segment and returns at the edge where it is accepted. Valid is only
	// lowered for an idle gap, so back-to-back beats keep it high without a glitch,
	// and the payload stays put while the block stalls.
	task automatic send_segment(input logic opens, input tuple_t tup);
		while ((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 69) ||
				(idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 25)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_of_sector <= opens;
		tex_index_a <= tup[0];
		tex_index_b <= tup[1];
		tex_index_c <= tup[2];
		tex_index_d <= tup[3];
		segments_sent++;
		idle_mode <= idle_mode_t'((segments_sent / PHASE_LEN) % 4);
		if (segments_sent == HOLD_AT_SEGMENT)
			hold_request <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// A short sector of random content: repeats, near misses and new tuples, with the
	// odd stray start flag in the middle that empties the table early.
	task automatic run_mixed_sector(input int len);
		tuple_t tup;
		logic   opens;
		int     i;
		int     roll;
		for (i = 0; i < len; i++) begin
			opens = (i == 0) || ($urandom_range(0, 99) < 3);
			if (opens)
				sector_tuples.delete();
			roll = $urandom_range(0, 99);
			if (sector_tuples.size() == 0 || roll < 30)
				tup = fresh_tuple();
			else if (roll < 75)
				tup = sector_tuples[$urandom_range(0, sector_tuples.size() - 1)];
			else
				tup = variant_of(sector_tuples[$urandom_range(0, sector_tuples.size() - 1)]);
			sector_tuples.push_back(tup);
			send_segment(opens, tup);
		end
	endtask

	// Fills every slot with distinct tuples, then keeps going: new tuples must be
	// dropped with the full flag and a saturated count, while repeats, the last slot
	// among them, must still be found.
	task automatic run_full_sector();
		tuple_t tup;
		int     i;
		sector_tuples.delete();
		for (i = 0; i < MAX_PATTERNS_DEF; i++) begin
			tup = {$urandom(), $urandom(), $urandom(), $urandom()};
			sector_tuples.push_back(tup);
			send_segment(i == 0, tup);
		end
		send_segment(1'b0, sector_tuples[MAX_PATTERNS_DEF - 1]);
		for (i = 0; i < 24; i++) begin
			if ($urandom_range(0, 99) < 40)
				tup = {$urandom(), $urandom(), $urandom(), $urandom()};
			else
				tup = sector_tuples[$urandom_range(0, MAX_PATTERNS_DEF - 1)];
			send_segment(1'b0, tup);
		end
	endtask

	// Receiver side. Stalls follow the idle mode, except for one long hold-off in the
	// middle of the run: the sender keeps offering beats, so the output register and
	// the search in flight both fill up and the block has to stall its input.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				out_stall <= 1'b0;
			end else if (draining) begin
				out_stall <= 1'b0;
			end else begin
				case (idle_mode)
					IDLE_RECEIVER: out_stall <= ($urandom_range(0, 99) < 69);
					IDLE_BOTH:     out_stall <= ($urandom_range(0, 99) < 25);
					default:       out_stall <= 1'b0;
				endcase
			end
		end
	end

	// Sender side and verdict.
	initial begin
		int fills_done;
		fills_done = 0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The first sector covers the extreme index values, a tuple that
		// differs from a stored one in exactly one field for each field, hits on early
		// and later slots, and alternating bit patterns with their complements.
		send_segment(1'b1, tuple_of('0, '0, '0, '0));
		send_segment(1'b0, tuple_of('0, '0, '0, '0));
		send_segment(1'b0, tuple_of('1, '1, '1, '1));
		send_segment(1'b0, tuple_of(32'h1, '0, '0, '0));
		send_segment(1'b0, tuple_of('0, 32'h1, '0, '0));
		send_segment(1'b0, tuple_of('0, '0, 32'h1, '0));
		send_segment(1'b0, tuple_of('0, '0, '0, 32'h1));
		send_segment(1'b0, tuple_of('1, '1, '1, '1));
		send_segment(1'b0, tuple_of(32'h8000_0000, '0, '0, '0));
		send_segment(1'b0, tuple_of('0, '0, '0, 32'h1));
		send_segment(1'b0, tuple_of(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
		send_segment(1'b0, tuple_of(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
		send_segment(1'b0, tuple_of(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
		// A start flag must empty the table even when the tuple was just stored, and
		// twice in a row as well.
		send_segment(1'b1, tuple_of('1, '1, '1, '1));
		send_segment(1'b1, tuple_of('1, '1, '1, '1));
		send_segment(1'b0, tuple_of('0, '0, '0, '0));
		send_segment(1'b0, tuple_of('1, '1, '1, '1));

		// Random part: mostly short sectors, with two sectors that run the table full.
		while (segments_sent < TARGET_SEGMENTS) begin
			if ((fills_done == 0 && segments_sent >= 200) ||
					(fills_done == 1 && segments_sent >= 600)) begin
				run_full_sector();
				fills_done++;
			end else begin
				run_mixed_sector($urandom_range(1, 30));
			end
		end
		in_valid <= 1'b0;
		draining <= 1'b1;

		// Let the last accepted beat reach the checker, wait for every result, then give
		// the block a full search time to show any result it should not produce.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
